### design/ipv4rx_pkg.sv
// Shared types and codes for the IPv4 receive header checker.
package ipv4rx_pkg;

  // Header fields gathered over one packet, passed from the accumulator to the verdict stage
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  version_ihl;
    logic [15:0] sum;
    logic [15:0] total_length;
    logic [15:0] frag;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
  } hdr_t;

  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_SHORT    = 3'd1;
  localparam logic [2:0] VERDICT_VERSION  = 3'd2;
  localparam logic [2:0] VERDICT_HDR_LEN  = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd4;
  localparam logic [2:0] VERDICT_TOT_LEN  = 3'd5;
  localparam logic [2:0] VERDICT_FRAGMENT = 3'd6;
  localparam logic [2:0] VERDICT_NOT_OURS = 3'd7;

  localparam logic [1:0] CLASS_ICMP  = 2'd0;
  localparam logic [1:0] CLASS_UDP   = 2'd1;
  localparam logic [1:0] CLASS_TCP   = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION    = 4'h4;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;

endpackage

### design/ipv4rx_hdr_accum.sv
// Byte counter, header field capture and running ones' complement sum.
module ipv4rx_hdr_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               fresh,
  input  logic               drop,
  input  logic [7:0]         data_byte,
  output ipv4rx_pkg::hdr_t   hdr
);

  localparam logic [15:0] OFS_VER_IHL   = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI   = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO   = 16'd3;
  localparam logic [15:0] OFS_FRAG_HI   = 16'd6;
  localparam logic [15:0] OFS_FRAG_LO   = 16'd7;
  localparam logic [15:0] OFS_PROTOCOL  = 16'd9;
  localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
  localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
  localparam logic [15:0] OFS_DST_FIRST = 16'd16;
  localparam logic [15:0] OFS_DST_LAST  = 16'd19;

  ipv4rx_pkg::hdr_t hdr_base;
  ipv4rx_pkg::hdr_t hdr_next;
  logic [7:0]       high_byte_hold;
  logic [7:0]       hold_base;
  logic [7:0]       hold_next;
  logic [5:0]       hlen_cur;
  logic [15:0]      idx;
  logic [16:0]      word_sum;

  always_comb begin
    // a finished packet still sitting here counts as cleared state
    hdr_base  = fresh ? '0 : hdr;
    hold_base = fresh ? 8'd0 : high_byte_hold;
    idx       = hdr_base.byte_count;
    hdr_next  = hdr_base;
    hold_next = hold_base;
    hlen_cur  = (idx == OFS_VER_IHL) ? {data_byte[3:0], 2'b00}
                                     : {hdr_base.version_ihl[3:0], 2'b00};
    word_sum  = {1'b0, hdr_base.sum} + {1'b0, hold_base, data_byte};
    if (word_sum > 17'h0FFFF) begin
      word_sum = word_sum - 17'h0FFFF;
    end
    if (idx != ipv4rx_pkg::COUNT_MAX) begin
      hdr_next.byte_count = idx + 16'd1;
      if (idx == OFS_VER_IHL) hdr_next.version_ihl = data_byte;
      if (idx == OFS_TLEN_HI) hdr_next.total_length[15:8] = data_byte;
      if (idx == OFS_TLEN_LO) hdr_next.total_length[7:0] = data_byte;
      if (idx == OFS_FRAG_HI) hdr_next.frag[15:8] = data_byte;
      if (idx == OFS_FRAG_LO) hdr_next.frag[7:0] = data_byte;
      if (idx == OFS_PROTOCOL) hdr_next.protocol = data_byte;
      if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) begin
        hdr_next.source = {hdr_base.source[23:0], data_byte};
      end
      if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) begin
        hdr_next.destination = {hdr_base.destination[23:0], data_byte};
      end
      if (!idx[0]) begin
        hold_next = data_byte;
      end else if (idx < {10'd0, hlen_cur}) begin
        hdr_next.sum = word_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr            <= '0;
      high_byte_hold <= 8'd0;
    end else if (take) begin
      hdr            <= hdr_next;
      high_byte_hold <= hold_next;
    end else if (drop) begin
      hdr            <= '0;
      high_byte_hold <= 8'd0;
    end
  end

endmodule

### design/ipv4rx_verdict.sv
// Header checks in priority order and the registered result beat.
module ipv4rx_verdict (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ipv4rx_pkg::hdr_t   hdr,
  input  logic [31:0]        local_ip,
  input  logic               result_stall,
  output logic               result_valid,
  output logic [2:0]         verdict,
  output logic [1:0]         protocol_class,
  output logic [31:0]        source_ip,
  output logic [15:0]        upper_length,
  output logic [5:0]         header_length
);

  logic [5:0]  hlen;
  logic [15:0] hlen_w;
  logic [2:0]  code;
  logic [1:0]  pclass;

  always_comb begin
    hlen   = {hdr.version_ihl[3:0], 2'b00};
    hlen_w = {10'd0, hlen};
    if (hdr.byte_count < ipv4rx_pkg::MIN_HDR_BYTES) begin
      code = ipv4rx_pkg::VERDICT_SHORT;
    end else if (hdr.version_ihl[7:4] != ipv4rx_pkg::IP_VERSION) begin
      code = ipv4rx_pkg::VERDICT_VERSION;
    end else if (hlen_w < ipv4rx_pkg::MIN_HDR_BYTES || hlen_w > hdr.byte_count) begin
      code = ipv4rx_pkg::VERDICT_HDR_LEN;
    end else if (hdr.sum != ipv4rx_pkg::SUM_GOOD) begin
      code = ipv4rx_pkg::VERDICT_CHECKSUM;
    end else if (hdr.total_length < hlen_w || hdr.total_length > hdr.byte_count) begin
      code = ipv4rx_pkg::VERDICT_TOT_LEN;
    end else if (hdr.frag[13] || (hdr.frag[12:0] != 13'd0)) begin
      code = ipv4rx_pkg::VERDICT_FRAGMENT;
    end else if (hdr.destination != local_ip && hdr.destination != ipv4rx_pkg::BCAST_ADDR) begin
      code = ipv4rx_pkg::VERDICT_NOT_OURS;
    end else begin
      code = ipv4rx_pkg::VERDICT_ACCEPT;
    end

    case (hdr.protocol)
      ipv4rx_pkg::PROTO_ICMP: pclass = ipv4rx_pkg::CLASS_ICMP;
      ipv4rx_pkg::PROTO_UDP:  pclass = ipv4rx_pkg::CLASS_UDP;
      ipv4rx_pkg::PROTO_TCP:  pclass = ipv4rx_pkg::CLASS_TCP;
      default:                pclass = ipv4rx_pkg::CLASS_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict       <= code;
      header_length <= hlen;
      if (code == ipv4rx_pkg::VERDICT_ACCEPT) begin
        protocol_class <= pclass;
        source_ip      <= hdr.source;
        upper_length   <= hdr.total_length - hlen_w;
      end else begin
        // reject: report no dispatch information
        protocol_class <= ipv4rx_pkg::CLASS_OTHER;
        source_ip      <= 32'd0;
        upper_length   <= 16'd0;
      end
    end
  end

endmodule

### design/ipv4_receive_header_check_top.sv
// Top level of the IPv4 receive header checker.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    data_byte, last_byte
//   result    out        result_valid / result_stall verdict, protocol_class,
//                                                   source_ip, upper_length,
//                                                   header_length
//   local_ip  in         local_ip_we                local_ip_wdata
//
// One byte beat per cycle is accepted while item_stall is low. A beat passes
// an input register, then updates the header state; a last beat's verdict is
// registered next, in the result register, once that register is free.
// Synchronous active-high rst clears the handshake flags, the header state
// and local_ip. A stalled result holds; while the finished packet cannot move
// into the result register, the input register holds one byte and stalls.
module ipv4_receive_header_check_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        local_ip_we,
  input  logic [31:0] local_ip_wdata,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  verdict,
  output logic [1:0]  protocol_class,
  output logic [31:0] source_ip,
  output logic [15:0] upper_length,
  output logic [5:0]  header_length
);

  logic             [31:0] local_ip;
  logic                    in_full;
  logic             [7:0]  in_byte;
  logic                    in_last;
  logic                    pend;
  logic                    out_free;
  logic                    pend_go;
  logic                    state_free;
  logic                    in_go;
  logic                    accept;
  ipv4rx_pkg::hdr_t        hdr;

  assign out_free   = !result_valid || !result_stall;
  assign pend_go    = pend && out_free;
  assign state_free = !pend || pend_go;
  assign in_go      = in_full && state_free;
  assign item_stall = in_full && !state_free;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= 32'd0;
    end else if (local_ip_we) begin
      local_ip <= local_ip_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      pend    <= 1'b0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (in_go) begin
        in_full <= 1'b0;
      end
      // a last beat leaves its packet waiting for the result register
      if (in_go) begin
        pend <= in_last;
      end else if (pend_go) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  ipv4rx_hdr_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (in_go),
    .fresh     (pend),
    .drop      (pend_go),
    .data_byte (in_byte),
    .hdr       (hdr)
  );

  ipv4rx_verdict u_verdict (
    .clk            (clk),
    .rst            (rst),
    .load           (pend_go),
    .hdr            (hdr),
    .local_ip       (local_ip),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .verdict        (verdict),
    .protocol_class (protocol_class),
    .source_ip      (source_ip),
    .upper_length   (upper_length),
    .header_length  (header_length)
  );

endmodule

### design/ipv4rx_check.sv
// Port-level assertions for the IPv4 receive header checker, bound to the top level.
module ipv4rx_check (
  input logic        clk,
  input logic        rst,
  input logic        local_ip_we,
  input logic [31:0] local_ip_wdata,
  input logic        item_valid,
  input logic        item_stall,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  verdict,
  input logic [1:0]  protocol_class,
  input logic [31:0] source_ip,
  input logic [15:0] upper_length,
  input logic [5:0]  header_length
);

  // a held result beat keeps its payload
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(verdict) &&
      $stable(protocol_class) && $stable(source_ip) && $stable(upper_length) &&
      $stable(header_length))
    else $error("result beat changed while stalled");

  // a rejected packet carries no dispatch information
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && verdict != ipv4rx_pkg::VERDICT_ACCEPT |->
      protocol_class == ipv4rx_pkg::CLASS_OTHER && source_ip == 32'd0 &&
      upper_length == 16'd0)
    else $error("rejected packet reports dispatch fields");

  // an accepted header is at least the minimum length, in whole words
  a_accept_hlen: assert property (@(posedge clk) disable iff (rst)
    result_valid && verdict == ipv4rx_pkg::VERDICT_ACCEPT |->
      {10'd0, header_length} >= ipv4rx_pkg::MIN_HDR_BYTES && header_length[1:0] == 2'b00)
    else $error("accepted packet with bad header length");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present after reset");

endmodule

bind ipv4_receive_header_check_top ipv4rx_check u_check (.*);

### tb/tb.sv
// Self-checking testbench for the IPv4 receive header checker, with a byte-level verdict predictor.
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  pclass;
    logic [31:0] src;
    logic [15:0] ulen;
    logic [5:0]  hlen;
  } ip_verdict_t;

  typedef enum logic [1:0] {CS_RAW, CS_FIX, CS_BREAK} csum_mode_t;

  typedef struct {
    int          n;
    logic [7:0]  vi;
    logic [15:0] tl;
    logic [15:0] fr;
    logic [7:0]  pr;
    logic [31:0] sa;
    logic [31:0] da;
    csum_mode_t  cm;
    bit          typed;
    ip_verdict_t want;
  } pkt_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        local_ip_we = 1'b0;
  logic [31:0] local_ip_wdata = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  verdict;
  logic [1:0]  protocol_class;
  logic [31:0] source_ip;
  logic [15:0] upper_length;
  logic [5:0]  header_length;

  ipv4_receive_header_check_top dut (
    .clk(clk), .rst(rst),
    .local_ip_we(local_ip_we), .local_ip_wdata(local_ip_wdata),
    .item_valid(item_valid), .item_stall(item_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .verdict(verdict), .protocol_class(protocol_class), .source_ip(source_ip),
    .upper_length(upper_length), .header_length(header_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the packet in flight
  logic [31:0] own_ip = '0;
  logic [15:0] hdr_count = '0;
  logic [7:0]  hdr_ver_ihl = '0;
  logic [16:0] hdr_csum = '0;
  logic [7:0]  hdr_even = '0;
  logic [15:0] hdr_tot_len = '0;
  logic [15:0] hdr_frag = '0;
  logic [7:0]  hdr_proto = '0;
  logic [31:0] hdr_src = '0;
  logic [31:0] hdr_dst = '0;

  ip_verdict_t pending_verdicts[$];
  logic [7:0]  pkt_bytes[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          sender_gaps = 1'b1;
  bit          receiver_gaps = 1'b1;
  bit          hold_req = 1'b0;

  function automatic bit judge_byte(input logic [7:0] b, input bit last,
                                    output ip_verdict_t res);
    int idx;
    int hl;
    int len;
    int s;
    logic [2:0] v;
    idx = hdr_count;
    if (hdr_count != ipv4rx_pkg::COUNT_MAX) begin
      hl = hdr_ver_ihl[3:0] * 4;
      if (idx == 0) begin
        hdr_ver_ihl = b;
        hl = b[3:0] * 4;
      end
      case (idx)
        2: hdr_tot_len[15:8] = b;
        3: hdr_tot_len[7:0] = b;
        6: hdr_frag[15:8] = b;
        7: hdr_frag[7:0] = b;
        9: hdr_proto = b;
        12, 13, 14, 15: hdr_src = {hdr_src[23:0], b};
        16, 17, 18, 19: hdr_dst = {hdr_dst[23:0], b};
        default: ;
      endcase
      if (idx % 2 == 0) begin
        hdr_even = b;
      end else if (idx < hl) begin
        s = hdr_csum + {hdr_even, b};
        if (s > 'hFFFF) s -= 'hFFFF;
        hdr_csum = 17'(s);
      end
      hdr_count = 16'(idx + 1);
    end
    if (!last) return 1'b0;

    len = hdr_count;
    hl = hdr_ver_ihl[3:0] * 4;
    if (len < ipv4rx_pkg::MIN_HDR_BYTES) v = ipv4rx_pkg::VERDICT_SHORT;
    else if (hdr_ver_ihl[7:4] != ipv4rx_pkg::IP_VERSION) v = ipv4rx_pkg::VERDICT_VERSION;
    else if (hl < ipv4rx_pkg::MIN_HDR_BYTES || hl > len) v = ipv4rx_pkg::VERDICT_HDR_LEN;
    else if (hdr_csum != ipv4rx_pkg::SUM_GOOD) v = ipv4rx_pkg::VERDICT_CHECKSUM;
    else if (hdr_tot_len < hl || hdr_tot_len > len) v = ipv4rx_pkg::VERDICT_TOT_LEN;
    else if (hdr_frag[13] || hdr_frag[12:0] != 0) v = ipv4rx_pkg::VERDICT_FRAGMENT;
    else if (hdr_dst != own_ip && hdr_dst != ipv4rx_pkg::BCAST_ADDR)
      v = ipv4rx_pkg::VERDICT_NOT_OURS;
    else v = ipv4rx_pkg::VERDICT_ACCEPT;

    res.verdict = v;
    res.pclass = ipv4rx_pkg::CLASS_OTHER;
    res.src = '0;
    res.ulen = '0;
    res.hlen = 6'(hl);
    if (v == ipv4rx_pkg::VERDICT_ACCEPT) begin
      if (hdr_proto == ipv4rx_pkg::PROTO_ICMP) res.pclass = ipv4rx_pkg::CLASS_ICMP;
      else if (hdr_proto == ipv4rx_pkg::PROTO_UDP) res.pclass = ipv4rx_pkg::CLASS_UDP;
      else if (hdr_proto == ipv4rx_pkg::PROTO_TCP) res.pclass = ipv4rx_pkg::CLASS_TCP;
      res.src = hdr_src;
      res.ulen = 16'(hdr_tot_len - hl);
    end

    // start over for the next packet
    hdr_count = '0;
    hdr_ver_ihl = '0;
    hdr_csum = '0;
    hdr_even = '0;
    hdr_tot_len = '0;
    hdr_frag = '0;
    hdr_proto = '0;
    hdr_src = '0;
    hdr_dst = '0;
    return 1'b1;
  endfunction

  function automatic void put_byte(input int idx, input logic [7:0] v);
    if (idx < pkt_bytes.size()) pkt_bytes[idx] = v;
  endfunction

  task automatic make_packet(input int n, input logic [7:0] vi, input logic [15:0] tl,
                             input logic [15:0] fr, input logic [7:0] pr,
                             input logic [31:0] sa, input logic [31:0] da,
                             input csum_mode_t cm);
    int hl;
    int s;
    logic [15:0] w;
    pkt_bytes.delete();
    for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom));
    put_byte(0, vi);
    put_byte(2, tl[15:8]);
    put_byte(3, tl[7:0]);
    put_byte(6, fr[15:8]);
    put_byte(7, fr[7:0]);
    put_byte(9, pr);
    for (int i = 0; i < 4; i++) begin
      put_byte(12 + i, sa[31 - 8 * i -: 8]);
      put_byte(16 + i, da[31 - 8 * i -: 8]);
    end
    hl = vi[3:0] * 4;
    if (cm != CS_RAW && hl >= 12 && hl <= n) begin
      put_byte(10, 8'h00);
      put_byte(11, 8'h00);
      s = 0;
      for (int j = 0; j < hl; j += 2) begin
        s += {pkt_bytes[j], pkt_bytes[j + 1]};
        if (s > 'hFFFF) s -= 'hFFFF;
      end
      w = ~16'(s);
      // shift the sum off zero so the header can never pass
      if (cm == CS_BREAK) w ^= 16'h0100;
      put_byte(10, w[15:8]);
      put_byte(11, w[7:0]);
    end
  endtask

  task automatic rand_packet();
    int k;
    int ihl;
    int hl;
    int n;
    logic [7:0]  vi;
    logic [7:0]  pr;
    logic [15:0] tl;
    logic [15:0] fr;
    logic [31:0] da;
    csum_mode_t  cm;
    k = $urandom_range(99);
    ihl = ($urandom_range(9) < 7) ? 5 : $urandom_range(6, 15);
    hl = ihl * 4;
    n = hl + $urandom_range(0, 12);
    vi = {ipv4rx_pkg::IP_VERSION, 4'(ihl)};
    tl = 16'($urandom_range(hl, n));
    fr = {1'($urandom), 1'($urandom), 14'd0};
    case ($urandom_range(3))
      0: pr = ipv4rx_pkg::PROTO_ICMP;
      1: pr = ipv4rx_pkg::PROTO_UDP;
      2: pr = ipv4rx_pkg::PROTO_TCP;
      default: pr = 8'($urandom);
    endcase
    da = $urandom_range(1) ? own_ip : ipv4rx_pkg::BCAST_ADDR;
    cm = CS_FIX;
    if (k >= 85) begin
      n = $urandom_range(1, 40);
      vi = 8'($urandom);
      tl = 16'($urandom);
      fr = 16'($urandom);
      da = $urandom;
      cm = CS_RAW;
    end else if (k >= 60) begin
      // one defect in an otherwise good header
      case ($urandom_range(6))
        0: n = $urandom_range(1, 19);
        1: vi[7:4] = 4'($urandom_range(5, 19));
        2: begin
          if (ihl > 5 && $urandom_range(1)) n = $urandom_range(20, hl - 1);
          else vi[3:0] = 4'($urandom_range(4));
        end
        3: cm = CS_BREAK;
        4: begin
          if ($urandom_range(1)) tl = 16'($urandom_range(0, hl - 1));
          else tl = 16'($urandom_range(n + 1, 65535));
        end
        5: begin
          if ($urandom_range(1)) fr[13] = 1'b1;
          else fr[12:0] = 13'($urandom_range(1, 8191));
        end
        default: da = $urandom;
      endcase
    end
    make_packet(n, vi, tl, fr, pr, $urandom, da, cm);
  endtask

  task automatic drive_beat(input logic [7:0] b, input logic l);
    while (sender_gaps && $urandom_range(99) < 19) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_packet(input bit typed, input ip_verdict_t want);
    ip_verdict_t got;
    int last_idx;
    last_idx = pkt_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) void'(judge_byte(pkt_bytes[i], i == last_idx, got));
    pending_verdicts.push_back(typed ? want : got);
    for (int i = 0; i <= last_idx; i++) drive_beat(pkt_bytes[i], i == last_idx);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_local_ip(input logic [31:0] v);
    local_ip_we <= 1'b1;
    local_ip_wdata <= v;
    @(posedge clk);
    local_ip_we <= 1'b0;
    own_ip = v;
  endtask

  function automatic pkt_row_t dir_row(input int n, input logic [7:0] vi, input logic [15:0] tl,
                                       input logic [15:0] fr, input logic [7:0] pr,
                                       input logic [31:0] sa, input logic [31:0] da,
                                       input csum_mode_t cm, input bit typed,
                                       input logic [2:0] v, input logic [1:0] c,
                                       input logic [31:0] src, input logic [15:0] ulen,
                                       input logic [5:0] hlen);
    pkt_row_t r;
    r.n = n;
    r.vi = vi;
    r.tl = tl;
    r.fr = fr;
    r.pr = pr;
    r.sa = sa;
    r.da = da;
    r.cm = cm;
    r.typed = typed;
    r.want = '{v, c, src, ulen, hlen};
    return r;
  endfunction

  initial begin : stimulus
    pkt_row_t    rows[20];
    logic [31:0] ip_plan[4];
    int          pkts;
    // local_ip is still zero from reset here
    rows[0]  = dir_row(1, 'h45, 0, 0, 6, 0, 0, CS_RAW, 1,
                       ipv4rx_pkg::VERDICT_SHORT, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[1]  = dir_row(19, 'h4F, 19, 0, 6, 0, 0, CS_RAW, 1,
                       ipv4rx_pkg::VERDICT_SHORT, ipv4rx_pkg::CLASS_OTHER, 0, 0, 60);
    rows[2]  = dir_row(20, 'h00, 20, 0, 0, 0, 0, CS_RAW, 1,
                       ipv4rx_pkg::VERDICT_VERSION, ipv4rx_pkg::CLASS_OTHER, 0, 0, 0);
    rows[3]  = dir_row(20, 'hF5, 20, 0, 6, 0, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_VERSION, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[4]  = dir_row(20, 'h44, 20, 0, 6, 0, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_HDR_LEN, ipv4rx_pkg::CLASS_OTHER, 0, 0, 16);
    rows[5]  = dir_row(20, 'h46, 20, 0, 6, 0, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_HDR_LEN, ipv4rx_pkg::CLASS_OTHER, 0, 0, 24);
    rows[6]  = dir_row(20, 'h45, 20, 0, 6, 'h0A000001, 0, CS_BREAK, 1,
                       ipv4rx_pkg::VERDICT_CHECKSUM, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[7]  = dir_row(20, 'h45, 19, 0, 6, 'h0A000001, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_TOT_LEN, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[8]  = dir_row(20, 'h45, 21, 0, 6, 'h0A000001, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_TOT_LEN, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[9]  = dir_row(20, 'h45, 20, 'h2000, 6, 'h0A000001, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_FRAGMENT, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[10] = dir_row(20, 'h45, 20, 'h0001, 6, 'h0A000001, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_FRAGMENT, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[11] = dir_row(20, 'h45, 20, 'hFFFF, 6, 'hFFFFFFFF, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_FRAGMENT, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[12] = dir_row(20, 'h45, 20, 0, 6, 'h0A000001, 'h01020304, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_NOT_OURS, ipv4rx_pkg::CLASS_OTHER, 0, 0, 20);
    rows[13] = dir_row(20, 'h45, 20, 'h4000, 6, 'h0A000001, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_ACCEPT, ipv4rx_pkg::CLASS_TCP, 'h0A000001, 0, 20);
    rows[14] = dir_row(28, 'h45, 28, 0, 1, 'hFFFFFFFF, 'hFFFFFFFF, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_ACCEPT, ipv4rx_pkg::CLASS_ICMP, 'hFFFFFFFF, 8, 20);
    rows[15] = dir_row(20, 'h45, 20, 0, 6, 0, 0, CS_FIX, 1,
                       ipv4rx_pkg::VERDICT_ACCEPT, ipv4rx_pkg::CLASS_TCP, 0, 0, 20);
    rows[16] = dir_row(64, 'h4F, 64, 0, 17, 'hC0A80101, 0, CS_FIX, 0, 0, 0, 0, 0, 0);
    rows[17] = dir_row(21, 'h45, 21, 'h8000, 'hFF, 'h7F000001, 0, CS_FIX, 0, 0, 0, 0, 0, 0);
    rows[18] = dir_row(30, 'h45, 24, 0, 0, 'h12345678, 'hFFFFFFFF, CS_FIX, 0, 0, 0, 0, 0, 0);
    rows[19] = dir_row(33, 'h5A, 'hBEEF, 'h1234, 'h99, 'hDEADBEEF, 'hCAFEF00D, CS_RAW, 0,
                       0, 0, 0, 0, 0);
    ip_plan[0] = $urandom;
    ip_plan[1] = 32'hFFFF_FFFF;
    ip_plan[2] = 32'h0000_0000;
    ip_plan[3] = $urandom;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      make_packet(rows[i].n, rows[i].vi, rows[i].tl, rows[i].fr, rows[i].pr,
                  rows[i].sa, rows[i].da, rows[i].cm);
      send_packet(rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      set_local_ip(ip_plan[ph]);
      sender_gaps = (ph != 1);
      receiver_gaps = (ph != 1);
      // hold the result side off while bytes keep coming
      if (ph == 2) hold_req = 1'b1;
      pkts = 0;
      while (pkts < ((ph == 2) ? 3 : 2)) begin
        rand_packet();
        send_packet(1'b0, '0);
        pkts++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_side
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= receiver_gaps && ($urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk) begin : result_check
    ip_verdict_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %0d/%0d/%h/%0d/%0d", verdict, protocol_class,
                   source_ip, upper_length, header_length);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict !== want.verdict || protocol_class !== want.pclass ||
            source_ip !== want.src || upper_length !== want.ulen ||
            header_length !== want.hlen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: want %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                     want.verdict, want.pclass, want.src, want.ulen, want.hlen,
                     verdict, protocol_class, source_ip, upper_length, header_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
